[design/osm_pkg.sv]
// osm_pkg: shared types and constants for the order statistic multiset.
// Holds the transfer structs, the sequencer state type and the cell control struct.
// No dependencies.
package osm_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int VALUE_BITS_DEF = 31;

  // fixed field widths of the transfer structs
  localparam int VAL_W   = 31;
  localparam int RANK_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [VAL_W-1:0]   value;
    logic [RANK_W-1:0]  rank;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]   kth_value;
    logic               rank_valid;
    logic               insert_dropped;
    logic               delete_found;
    logic [COUNT_W-1:0] element_count;
  } out_item_t;

  // update strobes broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEL
  } state_t;

endpackage

[design/order_statistic_multiset.sv]
// order_statistic_multiset: bounded sorted multiset with k-th smallest query.
// Top level: sequencer, element count and rank select over a row of osm_cell.
// Depends on osm_pkg and osm_cell.
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+------------------------------------
//  input    | start, busy, in_item        | transfer when start && !busy
//  result   | out_strobe, out_item        | one-cycle strobe, no back-pressure
//
// Sequence: the accept edge latches the command and enters ST_EXEC, where
// every cell updates at once (shift right for insert, shift left for delete);
// in ST_SEL the selected rank is registered and out_strobe is raised for one
// cycle. busy is high only in ST_EXEC, the update cycle, so a new start is
// taken on the same edge that registers the previous result.
// Reset: rst_n synchronous, active low; clears the count, the sequencer and out_strobe.
// Cell contents are not reset: only slots below the count are ever read.
// Stalls: the receiver cannot stall; each result is shown for one cycle.
module order_statistic_multiset #(
  parameter int CAPACITY   = osm_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = osm_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  osm_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output osm_pkg::out_item_t out_item
);
  import osm_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = CNT_W + RANK_W;

  // sequencer
  state_t state_r;
  state_t state_nxt;
  logic   accept;
  logic   exec_en;
  logic   sel_en;

  // latched command
  logic                  kind_r;
  logic [VALUE_BITS-1:0] key_r;
  logic [RANK_W-1:0]     rank_r;

  // store bookkeeping
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             full;
  logic             found;
  logic             dropped_r;
  logic             found_r;
  cell_ctl_t        ctl;

  // cell row
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]   cell_pos;
  logic [CAPACITY-1:0]   cell_eq;
  logic [CAPACITY-1:0]   cell_hit;

  // rank select
  logic                  rank_ok;
  logic [VALUE_BITS-1:0] sel_val;

  // result register
  logic      out_strobe_r;
  out_item_t out_item_r;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_SEL;
      ST_SEL:  state_nxt = accept ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    exec_en = 1'b0;
    sel_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_EXEC: begin
        busy    = 1'b1;
        exec_en = 1'b1;
      end
      ST_SEL:  sel_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command latch (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_item.kind;
      key_r  <= VALUE_BITS'(in_item.value);
      rank_r <= in_item.rank;
    end
  end

  // a delete hits if any occupied cell matches; the first match is where
  // the left shift begins
  assign full       = count_r == CNT_W'(CAPACITY);
  assign found      = |cell_eq;
  assign ctl.ins_en = exec_en && (kind_r == KIND_INSERT) && !full;
  assign ctl.del_en = exec_en && (kind_r == KIND_DELETE) && found;

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      dropped_r <= (kind_r == KIND_INSERT) && full;
      found_r   <= (kind_r == KIND_DELETE) && found;
    end
  end

  // row of cells: slot i is occupied while i < count
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  occ;
    logic                  at_end;
    logic                  left_pos;
    logic [VALUE_BITS-1:0] left_val;
    logic [VALUE_BITS-1:0] right_val;

    assign occ      = CNT_W'(i) < count_r;
    assign at_end   = CNT_W'(i) == count_r;
    assign cell_hit[i] = CMP_W'(i) == CMP_W'(rank_r);

    if (i == 0) begin : g_first
      assign left_pos = 1'b0;
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_pos = cell_pos[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    osm_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key      (key_r),
      .occ      (occ),
      .at_end   (at_end),
      .left_pos (left_pos),
      .left_val (left_val),
      .right_val(right_val),
      .val      (cell_val[i]),
      .pos      (cell_pos[i]),
      .eq       (cell_eq[i])
    );
  end

  // rank select: one-hot AND-OR over the row
  assign rank_ok = CMP_W'(rank_r) < CMP_W'(count_r);

  always_comb begin
    sel_val = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      sel_val = sel_val | (cell_hit[j] ? cell_val[j] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= sel_en;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_en) begin
      out_item_r.kth_value      <= rank_ok ? VAL_W'(sel_val) : '0;
      out_item_r.rank_valid     <= rank_ok;
      out_item_r.insert_dropped <= dropped_r;
      out_item_r.delete_found   <= found_r;
      out_item_r.element_count  <= COUNT_W'(count_r);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

[design/osm_cell.sv]
// osm_cell: one slot of the sorted cell row.
// Holds one value; shifts right on insert, left on delete. Uses osm_pkg.
module osm_cell #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  osm_pkg::cell_ctl_t    ctl,
  input  logic [VALUE_BITS-1:0] key,
  input  logic                  occ,
  input  logic                  at_end,
  input  logic                  left_pos,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic [VALUE_BITS-1:0] right_val,
  output logic [VALUE_BITS-1:0] val,
  output logic                  pos,
  output logic                  eq
);
  import osm_pkg::*;

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;
  logic                  ge;

  assign ge  = val_r >= key;
  assign eq  = occ && (val_r == key);
  // at or past the insertion point (first slot holding a larger value, or first free)
  assign pos = at_end || (occ && (val_r > key));
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en && pos) begin
      val_nxt = left_pos ? left_val : key;
    end else if (ctl.del_en && occ && ge) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
